// ===== rtl/core/fcbu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the fly camera basis update block.
package fcbu_pkg;

  localparam int ATAN_ENTRIES = 24;

  // Angles in Q9.16 degrees
  localparam logic signed [29:0] HALF_TURN   = 30'sd11796480;
  localparam logic signed [29:0] FULL_TURN   = 30'sd23592960;
  localparam logic signed [29:0] PITCH_LIMIT = 30'sd5832704;
  localparam logic signed [26:0] Z_QUARTER   = 27'sd5898240;
  localparam logic signed [26:0] Z_HALF      = 27'sd11796480;
  localparam logic signed [25:0] HEAD_RESET  = -26'sd5898240;

  // CORDIC gain start value in Q2.30
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam logic [15:0] ONE_Q14      = 16'd16384;
  localparam logic [15:0] SPEED_RESET  = 16'd640;
  localparam logic [15:0] GAIN_RESET   = 16'd6554;

  // Configuration register indexes
  localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
  localparam logic [2:0] REG_LOOK_GAIN  = 3'd1;
  localparam logic [2:0] REG_WORLD_UP_X = 3'd2;
  localparam logic [2:0] REG_WORLD_UP_Y = 3'd3;
  localparam logic [2:0] REG_WORLD_UP_Z = 3'd4;

  typedef enum logic [1:0] {
    RD_SQRT = 2'b01,
    RD_DIV  = 2'b10
  } rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_req_t;

  // Arctangent of 2^-i in Q9.16 degrees
  function automatic logic signed [26:0] atan_deg(input logic [4:0] idx);
    logic signed [26:0] v;
    case (idx)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/fcbu_cordic.sv =====
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC giving cos and sin of a Q9.16 degree angle in Q2.30.
module fcbu_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [26:0] angle,
  output logic               done,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  localparam int N  = (STEPS > fcbu_pkg::ATAN_ENTRIES) ? fcbu_pkg::ATAN_ENTRIES : STEPS;
  localparam int IW = $clog2(N);

  logic signed [32:0] x_r, y_r;
  logic signed [26:0] z_r;
  logic [IW-1:0]      i_r;
  logic               run_r, done_r, flip_r;
  logic signed [32:0] xs, ys;
  logic signed [26:0] at;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = fcbu_pkg::atan_deg(5'(i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // fold into +-90 degrees, negate both results afterwards
        if (angle > fcbu_pkg::Z_QUARTER) begin
          z_r    <= angle - fcbu_pkg::Z_HALF;
          flip_r <= 1'b1;
        end else if (angle < -fcbu_pkg::Z_QUARTER) begin
          z_r    <= angle + fcbu_pkg::Z_HALF;
          flip_r <= 1'b1;
        end else begin
          z_r    <= angle;
          flip_r <= 1'b0;
        end
        x_r   <= fcbu_pkg::CORDIC_START;
        y_r   <= '0;
        i_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == IW'(N - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign cos_out = flip_r ? 32'(-x_r) : x_r[31:0];
  assign sin_out = flip_r ? 32'(-y_r) : y_r[31:0];

endmodule

// ===== rtl/core/fcbu_rootdiv.sv =====
`timescale 1ns / 1ps
// Shared bit-serial unit: 64-bit integer square root or 16-bit-quotient division.
module fcbu_rootdiv (
  input  logic                clk,
  input  logic                rst_n,
  input  fcbu_pkg::rd_req_t   req,
  input  logic [63:0]         opa,
  input  logic [31:0]         den,
  output logic                done,
  output logic [31:0]         result
);

  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd15;

  logic [63:0]        v_r, r_r, b_r;
  logic [5:0]         cnt_r;
  logic               run_r, done_r;
  fcbu_pkg::rd_mode_t mode_r;
  logic [64:0]        rhs;
  logic               ge;
  logic [63:0]        diff;

  assign rhs  = (mode_r == fcbu_pkg::RD_SQRT) ? ({1'b0, r_r} + {1'b0, b_r}) : {1'b0, b_r};
  assign ge   = {1'b0, v_r} >= rhs;
  assign diff = v_r - rhs[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      mode_r <= fcbu_pkg::RD_SQRT;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        mode_r <= req.mode;
        v_r    <= opa;
        r_r    <= '0;
        run_r  <= 1'b1;
        if (req.mode == fcbu_pkg::RD_SQRT) begin
          b_r   <= 64'h4000_0000_0000_0000;
          cnt_r <= SQRT_LAST;
        end else begin
          b_r   <= {17'b0, den, 15'b0};
          cnt_r <= DIV_LAST;
        end
      end else if (run_r) begin
        if (ge) v_r <= diff;
        if (mode_r == fcbu_pkg::RD_SQRT) begin
          r_r <= ge ? ((r_r >> 1) + b_r) : (r_r >> 1);
          b_r <= b_r >> 2;
        end else begin
          r_r <= {r_r[62:0], ge};
          b_r <= b_r >> 1;
        end
        if (cnt_r == 6'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = r_r[31:0];

endmodule

// ===== rtl/core/fly_camera_basis_update.sv =====
`timescale 1ns / 1ps
// Top level of the fly camera basis update: sequencer, shared multiplier and state.
// The bit-serial root/divide unit does one 32-step root and three 16-step divides per
//   normalized vector of nonzero length.
// in_tready is high only while idle, so a new transaction is taken only after the
//   previous one is through.
// Reset: synchronous active low; afterwards the block rebuilds the basis from the
//   reset angles with in_tready low, then goes idle.
module fly_camera_basis_update #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // time_step[15:0], look_dx[31:16], look_dy[47:32], key_forward[48], key_back[49],
  // key_left[50], key_right[51], zero fill[55:52]
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], front_x/y/z[143:96],
  // side_x/y/z[191:144], up_x/y/z[239:192]
  output logic [239:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  typedef enum logic [26:0] {
    S_IDLE  = 27'b1 << 0,
    S_VEL   = 27'b1 << 1,
    S_VELW  = 27'b1 << 2,
    S_MF    = 27'b1 << 3,
    S_MR    = 27'b1 << 4,
    S_MA    = 27'b1 << 5,
    S_DH    = 27'b1 << 6,
    S_DE    = 27'b1 << 7,
    S_EL    = 27'b1 << 8,
    S_WRAP  = 27'b1 << 9,
    S_CH    = 27'b1 << 10,
    S_CHW   = 27'b1 << 11,
    S_CP    = 27'b1 << 12,
    S_CPW   = 27'b1 << 13,
    S_FX    = 27'b1 << 14,
    S_FZ    = 27'b1 << 15,
    S_FZW   = 27'b1 << 16,
    S_NSQ   = 27'b1 << 17,
    S_NACC  = 27'b1 << 18,
    S_NRT   = 27'b1 << 19,
    S_NRTW  = 27'b1 << 20,
    S_NDIV  = 27'b1 << 21,
    S_NDIVW = 27'b1 << 22,
    S_X1    = 27'b1 << 23,
    S_X2    = 27'b1 << 24,
    S_X3    = 27'b1 << 25,
    S_DONE  = 27'b1 << 26
  } state_t;

  // which vector the normalize pass is producing
  typedef enum logic [2:0] {
    P_FRONT = 3'b001,
    P_SIDE  = 3'b010,
    P_UP    = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r;

  // configuration
  logic [15:0]        speed_r, gain_r;
  logic signed [15:0] wu_r [3];

  // latched transaction
  logic [15:0]        ts_r;
  logic signed [15:0] dx_r, dy_r;
  logic [3:0]         keys_r;   // forward, back, left, right from bit 0 up
  logic               item_r;

  // architectural state
  logic [31:0]        pos_r   [3];
  logic signed [25:0] head_r, elev_r;
  logic signed [15:0] front_r [3];
  logic signed [15:0] side_r  [3];
  logic signed [15:0] up_r    [3];

  // working registers
  logic [23:0]        vel_r;
  logic [31:0]        df_r;
  logic signed [29:0] hsum_r;
  logic signed [31:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [31:0] raw_r [3];
  logic signed [31:0] t_r;
  logic [63:0]        sum_r;
  logic [31:0]        len_r;
  logic [1:0]         k_r;
  logic signed [63:0] prod_r;

  logic               out_tvalid_r;
  logic [239:0]       out_tdata_r;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;

  logic [1:0]         kp1, kp2;
  logic signed [15:0] ca [3];
  logic signed [15:0] cb [3];
  logic signed [29:0] delta, esum;
  logic [31:0]        dr, pos_new, mag;
  logic [63:0]        num;
  logic [15:0]        qv, nval, vec_val;
  logic               vec_we;
  logic               k_last;
  state_t             adv_state;

  fcbu_pkg::rd_req_t  rd_req;
  logic [63:0]        rd_opa;
  logic               rd_done;
  logic [31:0]        rd_result;

  logic               cd_start, cd_done;
  logic signed [26:0] cd_angle;
  logic signed [31:0] cd_cos, cd_sin;

  fcbu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cd_start),
    .angle   (cd_angle),
    .done    (cd_done),
    .cos_out (cd_cos),
    .sin_out (cd_sin)
  );

  fcbu_rootdiv u_rootdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rd_req),
    .opa    (rd_opa),
    .den    (len_r),
    .done   (rd_done),
    .result (rd_result)
  );

  assign kp1    = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
  assign kp2    = (k_r == 2'd0) ? 2'd2 : k_r - 2'd1;
  assign k_last = (k_r == 2'd2);

  // cross operands: side = front x world_up, up = side x front
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (phase_r == P_UP) begin
        ca[i] = side_r[i];
        cb[i] = front_r[i];
      end else begin
        ca[i] = front_r[i];
        cb[i] = wu_r[i];
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_VEL: begin
        mul_a = {16'b0, speed_r};
        mul_b = {16'b0, ts_r};
      end
      S_MF: begin
        mul_a = 32'(front_r[k_r]);
        mul_b = {8'b0, vel_r};
      end
      S_MR: begin
        mul_a = 32'(side_r[k_r]);
        mul_b = {8'b0, vel_r};
      end
      S_DH: begin
        mul_a = 32'(dx_r);
        mul_b = {16'b0, gain_r};
      end
      S_DE: begin
        mul_a = 32'(dy_r);
        mul_b = {16'b0, gain_r};
      end
      S_FX: begin
        mul_a = cy_r;
        mul_b = cp_r;
      end
      S_FZ: begin
        mul_a = sy_r;
        mul_b = cp_r;
      end
      S_NSQ: begin
        mul_a = raw_r[k_r];
        mul_b = raw_r[k_r];
      end
      S_X1: begin
        mul_a = 32'(ca[kp1]);
        mul_b = 32'(cb[kp2]);
      end
      S_X2: begin
        mul_a = 32'(ca[kp2]);
        mul_b = 32'(cb[kp1]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floor shifts of the product fall out of the bit slices
  assign delta = $signed(prod_r[33:4]);
  assign esum  = 30'(elev_r) + delta;
  assign dr    = prod_r[45:14];

  always_comb begin
    pos_new = pos_r[k_r];
    if (keys_r[0]) pos_new = pos_new + df_r;
    if (keys_r[1]) pos_new = pos_new - df_r;
    if (keys_r[2]) pos_new = pos_new - dr;
    if (keys_r[3]) pos_new = pos_new + dr;
  end

  // rounded quotient: (|c| * 2^14 + len/2) / len, limited to one
  assign mag  = raw_r[k_r][31] ? 32'(-raw_r[k_r]) : raw_r[k_r];
  assign num  = {18'b0, mag, 14'b0} + {33'b0, len_r[31:1]};
  assign qv   = (rd_result > 32'(fcbu_pkg::ONE_Q14)) ? fcbu_pkg::ONE_Q14 : rd_result[15:0];
  assign nval = raw_r[k_r][31] ? 16'(-qv) : qv;

  always_comb begin
    vec_we  = 1'b0;
    vec_val = nval;
    if (state_r == S_NDIV && len_r == '0) begin
      vec_we  = 1'b1;
      vec_val = '0;
    end else if (state_r == S_NDIVW && rd_done) begin
      vec_we = 1'b1;
    end
  end

  always_comb begin
    adv_state = S_NDIV;
    if (k_last) begin
      if (phase_r == P_UP) adv_state = item_r ? S_DONE : S_IDLE;
      else                 adv_state = S_X1;
    end
  end

  assign rd_req.start = (state_r == S_NRT) || (state_r == S_NDIV && len_r != '0);
  assign rd_req.mode  = (state_r == S_NRT) ? fcbu_pkg::RD_SQRT : fcbu_pkg::RD_DIV;
  assign rd_opa       = (state_r == S_NRT) ? sum_r : num;

  assign cd_start = (state_r == S_CH) || (state_r == S_CP);
  assign cd_angle = (state_r == S_CP) ? 27'(elev_r) : 27'(head_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_VEL;
      S_VEL:   state_nxt = S_VELW;
      S_VELW:  state_nxt = S_MF;
      S_MF:    state_nxt = S_MR;
      S_MR:    state_nxt = S_MA;
      S_MA:    state_nxt = k_last ? S_DH : S_MF;
      S_DH:    state_nxt = S_DE;
      S_DE:    state_nxt = S_EL;
      S_EL:    state_nxt = S_WRAP;
      S_WRAP:  if (hsum_r >= 0 && hsum_r < fcbu_pkg::FULL_TURN) state_nxt = S_CH;
      S_CH:    state_nxt = S_CHW;
      S_CHW:   if (cd_done) state_nxt = S_CP;
      S_CP:    state_nxt = S_CPW;
      S_CPW:   if (cd_done) state_nxt = S_FX;
      S_FX:    state_nxt = S_FZ;
      S_FZ:    state_nxt = S_FZW;
      S_FZW:   state_nxt = S_NSQ;
      S_NSQ:   state_nxt = S_NACC;
      S_NACC:  state_nxt = k_last ? S_NRT : S_NSQ;
      S_NRT:   state_nxt = S_NRTW;
      S_NRTW:  if (rd_done) state_nxt = S_NDIV;
      S_NDIV:  state_nxt = (len_r == '0) ? adv_state : S_NDIVW;
      S_NDIVW: if (rd_done) state_nxt = adv_state;
      S_X1:    state_nxt = S_X2;
      S_X2:    state_nxt = S_X3;
      S_X3:    state_nxt = k_last ? S_NSQ : S_X1;
      S_DONE:  if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CH;          // rebuild the basis from the reset angles
      phase_r      <= P_FRONT;
      item_r       <= 1'b0;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
      speed_r      <= fcbu_pkg::SPEED_RESET;
      gain_r       <= fcbu_pkg::GAIN_RESET;
      wu_r[0]      <= '0;
      wu_r[1]      <= $signed(fcbu_pkg::ONE_Q14);
      wu_r[2]      <= '0;
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
      head_r       <= fcbu_pkg::HEAD_RESET;
      elev_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          fcbu_pkg::REG_MOVE_SPEED: speed_r <= cfg_data;
          fcbu_pkg::REG_LOOK_GAIN:  gain_r  <= cfg_data;
          fcbu_pkg::REG_WORLD_UP_X: wu_r[0] <= $signed(cfg_data);
          fcbu_pkg::REG_WORLD_UP_Y: wu_r[1] <= $signed(cfg_data);
          fcbu_pkg::REG_WORLD_UP_Z: wu_r[2] <= $signed(cfg_data);
          default: ;                // drop writes beyond the register list
        endcase
      end

      // the done state reloads the output itself
      if (out_tvalid_r && out_tready && state_r != S_DONE) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: if (in_tvalid) item_r <= 1'b1;
        S_MA: begin
          pos_r[k_r] <= pos_new;
          k_r        <= k_last ? 2'd0 : kp1;
        end
        S_EL: begin
          if (esum > fcbu_pkg::PITCH_LIMIT)       elev_r <= 26'(fcbu_pkg::PITCH_LIMIT);
          else if (esum < -fcbu_pkg::PITCH_LIMIT) elev_r <= 26'(-fcbu_pkg::PITCH_LIMIT);
          else                                    elev_r <= 26'(esum);
        end
        S_WRAP: begin
          if (hsum_r >= 0 && hsum_r < fcbu_pkg::FULL_TURN) begin
            head_r  <= 26'(hsum_r - fcbu_pkg::HALF_TURN);
            phase_r <= P_FRONT;
          end
        end
        S_NACC:  k_r <= k_last ? 2'd0 : kp1;
        S_NRTW:  if (rd_done) k_r <= '0;
        S_NDIV, S_NDIVW: begin
          if (vec_we) begin
            k_r <= k_last ? 2'd0 : kp1;
            if (k_last) begin
              case (phase_r)
                P_FRONT: phase_r <= P_SIDE;
                P_SIDE:  phase_r <= P_UP;
                default: phase_r <= P_FRONT;
              endcase
            end
          end
        end
        S_X3: k_r <= k_last ? 2'd0 : kp1;
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            item_r       <= 1'b0;
          end
        end
        default: ;
      endcase

      if (vec_we) begin
        case (phase_r)
          P_FRONT: front_r[k_r] <= vec_val;
          P_SIDE:  side_r[k_r]  <= vec_val;
          default: up_r[k_r]    <= vec_val;
        endcase
      end
    end
  end

  // datapath payload, no reset
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ts_r   <= in_tdata[15:0];
          dx_r   <= $signed(in_tdata[31:16]);
          dy_r   <= $signed(in_tdata[47:32]);
          keys_r <= in_tdata[51:48];
        end
      end
      S_VELW: vel_r  <= prod_r[31:8];
      S_MR:   df_r   <= prod_r[45:14];
      S_DE:   hsum_r <= 30'(head_r) + delta + fcbu_pkg::HALF_TURN;
      S_WRAP: begin
        // bring yaw + half turn into one full turn
        if (hsum_r >= fcbu_pkg::FULL_TURN) hsum_r <= hsum_r - fcbu_pkg::FULL_TURN;
        else if (hsum_r < 0)               hsum_r <= hsum_r + fcbu_pkg::FULL_TURN;
      end
      S_CHW: begin
        if (cd_done) begin
          cy_r <= cd_cos;
          sy_r <= cd_sin;
        end
      end
      S_CPW: begin
        if (cd_done) begin
          cp_r <= cd_cos;
          sp_r <= cd_sin;
        end
      end
      S_FZ:  raw_r[0] <= $signed(prod_r[61:30]);
      S_FZW: begin
        raw_r[2] <= $signed(prod_r[61:30]);
        raw_r[1] <= sp_r;
      end
      S_NSQ:  if (k_r == 2'd0) sum_r <= '0;
      S_NACC: sum_r <= sum_r + prod_r;
      S_NRTW: if (rd_done) len_r <= rd_result;
      S_X2:   t_r <= $signed(prod_r[31:0]);
      S_X3:   raw_r[k_r] <= t_r - $signed(prod_r[31:0]);
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {up_r[2], up_r[1], up_r[0],
                          side_r[2], side_r[1], side_r[0],
                          front_r[2], front_r[1], front_r[0],
                          pos_r[2], pos_r[1], pos_r[0]};
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/core/fcbu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the fly camera basis update block and its bind.
module fcbu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [239:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // busy after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction is in progress");

  // basis rebuild after reset keeps both sides quiet
  a_boot: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("activity right after reset");

  // a result only appears while busy, never straight from idle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result without a transaction");

endmodule

bind fly_camera_basis_update fcbu_checker u_fcbu_checker (.*);
